@@ hdl/ttlt_pkg.sv @@
// Shared types, constants and level functions for the thermal throttle level tracker.
package ttlt_pkg;

   localparam int TEMP_W     = 16;
   localparam int TIME_W     = 64;
   localparam int LEVEL_W    = 3;
   localparam int BAND_W     = 12;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LIMIT_W    = TEMP_W + 2;
   // quotient of a 64-bit span by one minute fits in 29 bits
   localparam int QUOT_W     = 29;

   // one minute is MINUTE_ODD << MIN_SHIFT ns; the span >> MIN_SHIFT is split
   // into a high and a low part, each multiplied by the reciprocal
   localparam int MIN_SHIFT  = 11;
   localparam int DIV_W      = 25;
   localparam int REM_W      = DIV_W + 1;
   localparam int RECIP_W    = 29;
   localparam int EHI_W      = 26;
   localparam int ELO_W      = 27;
   localparam int PHI_W      = EHI_W + RECIP_W;
   localparam int PLO_W      = ELO_W + RECIP_W;
   localparam int PQD_W      = QUOT_W + DIV_W;

   localparam logic [TIME_W-1:0]  MINUTE_NS    = 64'd60_000_000_000;
   localparam logic [DIV_W-1:0]   MINUTE_ODD   = 25'd29296875;
   // floor(2**53 / MINUTE_ODD); the quotient estimate is low by at most one
   localparam logic [RECIP_W-1:0] MINUTE_RECIP = 29'd307445734;

   localparam logic signed [TEMP_W-1:0] LIGHT_RST    = 16'sd1200;
   localparam logic signed [TEMP_W-1:0] MODERATE_RST = 16'sd1280;
   localparam logic signed [TEMP_W-1:0] HEAVY_RST    = 16'sd1360;
   localparam logic signed [TEMP_W-1:0] SHUTDOWN_RST = 16'sd1520;
   localparam logic [BAND_W-1:0]        BAND_RST     = 12'd48;
   localparam logic signed [TEMP_W-1:0] WARN_RST     = 16'sd1120;
   localparam logic signed [TEMP_W-1:0] CRIT_RST     = 16'sd1360;

   typedef enum logic [LEVEL_W-1:0] {
      LVL_NONE,
      LVL_LIGHT,
      LVL_MODERATE,
      LVL_HEAVY,
      LVL_SHUTDOWN
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT,
      CSR_MODERATE,
      CSR_HEAVY,
      CSR_SHUTDOWN,
      CSR_BAND,
      CSR_WARN,
      CSR_CRIT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ACCUM,
      ST_EST,
      ST_REM,
      ST_FIX,
      ST_COUNT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic accum;
      logic est;
      logic rem;
      logic fix;
      logic count;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_sts_type;

   // t < thr - band, at full precision
   function automatic logic below_band(input logic signed [TEMP_W-1:0] t,
                                       input logic signed [TEMP_W-1:0] thr,
                                       input logic [BAND_W-1:0] band);
      logic signed [LIMIT_W-1:0] te;
      logic signed [LIMIT_W-1:0] lim;
      begin
         te  = $signed({{2{t[TEMP_W-1]}}, t});
         lim = $signed({{2{thr[TEMP_W-1]}}, thr})
               - $signed({{(LIMIT_W-BAND_W){1'b0}}, band});
         below_band = (te < lim);
      end
   endfunction

   function automatic level_type next_level(input logic signed [TEMP_W-1:0] t,
                                            input level_type cur_in,
                                            input logic signed [TEMP_W-1:0] lt,
                                            input logic signed [TEMP_W-1:0] mt,
                                            input logic signed [TEMP_W-1:0] ht,
                                            input logic signed [TEMP_W-1:0] st,
                                            input logic [BAND_W-1:0] band);
      level_type cur;
      level_type nl;
      begin
         cur = cur_in;
         if (cur == LVL_SHUTDOWN && below_band(t, st, band)) cur = LVL_HEAVY;
         if (cur == LVL_HEAVY && below_band(t, ht, band)) cur = LVL_MODERATE;
         if (cur == LVL_MODERATE && below_band(t, mt, band)) cur = LVL_LIGHT;
         if (cur == LVL_LIGHT && below_band(t, lt, band)) cur = LVL_NONE;
         if (t >= st) nl = LVL_SHUTDOWN;
         else if (t >= ht && cur < LVL_HEAVY) nl = LVL_HEAVY;
         else if (t >= mt && cur < LVL_MODERATE) nl = LVL_MODERATE;
         else if (t >= lt && cur < LVL_LIGHT) nl = LVL_LIGHT;
         else nl = cur;
         next_level = nl;
      end
   endfunction

endpackage

@@ hdl/ttlt_req_if.sv @@
// Request channel: one temperature sample with its timestamp.
interface ttlt_req_if;
   import ttlt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   logic [TIME_W-1:0]        sample_time;

   modport source (output valid, output temperature, output sample_time, input ready);
   modport sink (input valid, input temperature, input sample_time, output ready);
endinterface

@@ hdl/ttlt_rsp_if.sv @@
// Response channel: throttle level and accumulated counters.
interface ttlt_rsp_if;
   import ttlt_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] throttle_level;
   logic               is_shutdown;
   logic               level_changed;
   logic [TIME_W-1:0]  throttled_time_total;
   logic [COUNT_W-1:0] warn_minute_count;
   logic [COUNT_W-1:0] crit_minute_count;

   modport source (output valid, output throttle_level, output is_shutdown,
                   output level_changed, output throttled_time_total,
                   output warn_minute_count, output crit_minute_count, input ready);
   modport sink (input valid, input throttle_level, input is_shutdown,
                 input level_changed, input throttled_time_total,
                 input warn_minute_count, input crit_minute_count, output ready);
endinterface

@@ hdl/ttlt_dp.sv @@
// Datapath: config registers, tracker state, minute divider and response registers.
module ttlt_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  ttlt_pkg::dp_cmd_type               cmd,
   output ttlt_pkg::dp_sts_type               sts,
   input  logic signed [ttlt_pkg::TEMP_W-1:0] req_temperature,
   input  logic [ttlt_pkg::TIME_W-1:0]        req_sample_time,
   input  logic                               csr_wr_en,
   input  logic [ttlt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttlt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [ttlt_pkg::LEVEL_W-1:0]       rsp_throttle_level,
   output logic                               rsp_is_shutdown,
   output logic                               rsp_level_changed,
   output logic [ttlt_pkg::TIME_W-1:0]        rsp_throttled_time_total,
   output logic [ttlt_pkg::COUNT_W-1:0]       rsp_warn_minute_count,
   output logic [ttlt_pkg::COUNT_W-1:0]       rsp_crit_minute_count
);
   import ttlt_pkg::*;

   logic signed [TEMP_W-1:0] light_ff, moderate_ff, heavy_ff, shutdown_ff;
   logic signed [TEMP_W-1:0] warn_lim_ff, crit_lim_ff;
   logic [BAND_W-1:0]        band_ff;

   logic signed [TEMP_W-1:0] temp_ff;
   logic [TIME_W-1:0]        now_ff;
   level_type                level_ff;
   logic [TIME_W-1:0]        entry_ff;
   logic [TIME_W-1:0]        mark_ff;
   logic [TIME_W-1:0]        total_ff;
   logic [COUNT_W-1:0]       warn_ff;
   logic [COUNT_W-1:0]       crit_ff;

   logic                     changed_ff;
   logic                     add_ok_ff;
   logic [TIME_W-1:0]        span_ff;
   logic [TIME_W-1:0]        elapsed_ff;
   logic                     started_ff;
   logic                     mark_zero_ff;
   logic                     warn_hit_ff;
   logic                     crit_hit_ff;
   logic [PHI_W-1:0]         prod_hi_ff;
   logic [PLO_W-1:0]         prod_lo_ff;
   logic [QUOT_W-1:0]        qest_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [QUOT_W-1:0]        quot_ff;

   level_type                nl_in;
   logic [EHI_W+ELO_W-1:0]   span_min_in;
   logic [PHI_W:0]           est_in;
   logic [PQD_W-1:0]         qd_in;
   logic [PQD_W-1:0]         rem_full_in;
   logic                     rem_over_in;
   logic [REM_W-1:0]         rem_fix_in;
   logic [TIME_W-1:0]        rest_in;

   assign nl_in   = next_level(temp_ff, level_ff, light_ff, moderate_ff, heavy_ff,
                               shutdown_ff, band_ff);

   // elapsed / minute = (elapsed >> 11) / MINUTE_ODD, by reciprocal plus one correction
   assign span_min_in = elapsed_ff[TIME_W-1:MIN_SHIFT];
   assign est_in      = {1'b0, prod_hi_ff} + (PHI_W+1)'(prod_lo_ff[PLO_W-1:ELO_W]);
   assign qd_in       = PQD_W'(qest_ff) * PQD_W'(MINUTE_ODD);
   assign rem_full_in = PQD_W'(span_min_in) - qd_in;
   assign rem_over_in = (rem_ff >= REM_W'(MINUTE_ODD));
   assign rem_fix_in  = rem_over_in ? rem_ff - REM_W'(MINUTE_ODD) : rem_ff;
   // time past the last whole minute
   assign rest_in     = TIME_W'({rem_fix_in, elapsed_ff[MIN_SHIFT-1:0]});

   assign sts.need_div = started_ff && (elapsed_ff >= MINUTE_NS);

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff    <= LIGHT_RST;
         moderate_ff <= MODERATE_RST;
         heavy_ff    <= HEAVY_RST;
         shutdown_ff <= SHUTDOWN_RST;
         band_ff     <= BAND_RST;
         warn_lim_ff <= WARN_RST;
         crit_lim_ff <= CRIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LIGHT:    light_ff    <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_MODERATE: moderate_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_HEAVY:    heavy_ff    <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_SHUTDOWN: shutdown_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_BAND:     band_ff     <= csr_wdata[BAND_W-1:0];
            CSR_WARN:     warn_lim_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_CRIT:     crit_lim_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LVL_NONE;
         entry_ff <= '0;
         mark_ff  <= '0;
         total_ff <= '0;
         warn_ff  <= '0;
         crit_ff  <= '0;
      end else begin
         if (cmd.eval && nl_in != level_ff) begin
            level_ff <= nl_in;
            entry_ff <= now_ff;
         end
         if (cmd.accum) begin
            if (add_ok_ff) total_ff <= total_ff + span_ff;
            if (mark_zero_ff) mark_ff <= now_ff;
         end
         if (cmd.fix) mark_ff <= now_ff - rest_in;
         if (cmd.count) begin
            if (warn_hit_ff) warn_ff <= warn_ff + COUNT_W'(quot_ff);
            if (crit_hit_ff) crit_ff <= crit_ff + COUNT_W'(quot_ff);
         end
      end
   end

   // per-request working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_ff <= req_temperature;
         now_ff  <= req_sample_time;
      end
      if (cmd.eval) begin
         changed_ff   <= (nl_in != level_ff);
         add_ok_ff    <= (nl_in != level_ff) && (level_ff != LVL_NONE) && (now_ff > entry_ff);
         span_ff      <= now_ff - entry_ff;
         elapsed_ff   <= now_ff - mark_ff;
         mark_zero_ff <= (mark_ff == '0);
         started_ff   <= (mark_ff != '0) && (now_ff >= mark_ff);
         warn_hit_ff  <= (temp_ff >= warn_lim_ff);
         crit_hit_ff  <= (temp_ff >= crit_lim_ff);
      end
      if (cmd.accum) begin
         quot_ff    <= '0;
         prod_hi_ff <= PHI_W'(span_min_in[EHI_W+ELO_W-1:ELO_W]) * PHI_W'(MINUTE_RECIP);
         prod_lo_ff <= PLO_W'(span_min_in[ELO_W-1:0]) * PLO_W'(MINUTE_RECIP);
      end
      if (cmd.est) qest_ff <= est_in[EHI_W+QUOT_W-1:EHI_W];
      if (cmd.rem) rem_ff <= rem_full_in[REM_W-1:0];
      if (cmd.fix) quot_ff <= rem_over_in ? qest_ff + QUOT_W'(1) : qest_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_throttle_level       <= level_ff;
         rsp_is_shutdown          <= (level_ff == LVL_SHUTDOWN);
         rsp_level_changed        <= changed_ff;
         rsp_throttled_time_total <= total_ff;
         rsp_warn_minute_count    <= warn_ff;
         rsp_crit_minute_count    <= crit_ff;
      end
   end

endmodule

@@ hdl/ttlt_ctrl.sv @@
// Controller: sequences one request through evaluate, accumulate, divide, count and finish.
module ttlt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ttlt_pkg::dp_cmd_type cmd,
   input  ttlt_pkg::dp_sts_type sts
);
   import ttlt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = sts.need_div ? ST_EST : ST_COUNT;
         end
         ST_EST: begin
            cmd.est  = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.rem  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while pending");
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished request not presented");
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL && !cmd.load))
      else $error("accepted request not evaluated");
   a_fix_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |=> (state_ff == ST_COUNT))
      else $error("divider did not hand over to count");

endmodule

@@ hdl/thermal_throttle_level_tracker.sv @@
// Top level of the thermal throttle level tracker.
// Each request carries a signed temperature (1/16 degree C) and a nanosecond
// timestamp; each yields exactly one response with the new throttle level
// (0 none .. 4 shutdown, with hysteresis on the way down), a level-change flag,
// the running throttled-time total and the warn and critical minute counters.
// An accepted request passes the evaluate, accumulate, count and finish states
// (finish registers the response) if no whole minute has passed since the minute
// mark; else the estimate, remainder and fix states come before count, as the
// elapsed minutes come from a reciprocal multiplication by one minute with one
// correction step. A new request is taken the cycle after the response is
// registered, consumed or not; a waiting response holds the next request in its
// final cycle until the older one is taken. Configuration registers are written
// through the csr_ port only while idle, which the user, not the block, ensures.
module thermal_throttle_level_tracker (
   input  logic                            clock,
   input  logic                            reset,
   ttlt_req_if.sink                        req_if,
   ttlt_rsp_if.source                      rsp_if,
   input  logic                            csr_wr_en,
   input  logic [ttlt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ttlt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ttlt_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   ttlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ttlt_dp u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .sts                      (sts),
      .req_temperature          (req_if.temperature),
      .req_sample_time          (req_if.sample_time),
      .csr_wr_en                (csr_wr_en),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .rsp_throttle_level       (rsp_if.throttle_level),
      .rsp_is_shutdown          (rsp_if.is_shutdown),
      .rsp_level_changed        (rsp_if.level_changed),
      .rsp_throttled_time_total (rsp_if.throttled_time_total),
      .rsp_warn_minute_count    (rsp_if.warn_minute_count),
      .rsp_crit_minute_count    (rsp_if.crit_minute_count)
   );

endmodule
